FILE: sv/fltab_pkg.sv
// shared types and codes for the free-list handle table
`default_nettype none

package fltab_pkg;

    localparam int ACTION_W = 2;
    localparam int ID_W     = 7;
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_VISIT  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     slot_id;
        logic [VALUE_W-1:0]  object_value;
        logic                range_err;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/fltab_front.sv
// front stage: unpacks input transactions and flags out-of-range ids
`default_nettype none

module fltab_front #(
    parameter int CAPACITY = 64
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [fltab_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [fltab_pkg::ACTION_W-1:0]  s_tuser,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output fltab_pkg::cmd_t                  cmd
);
    import fltab_pkg::*;

    logic hold_valid_reg, hold_valid_next;
    cmd_t hold_reg, hold_next;
    cmd_t in_cmd;

    always_comb begin
        in_cmd.action       = s_tuser;
        in_cmd.slot_id      = s_tdata[ID_W-1:0];
        in_cmd.object_value = s_tdata[ID_W+VALUE_W-1:ID_W];
        in_cmd.range_err    = (s_tdata[ID_W-1:0] >= ID_W'(CAPACITY));
    end

    assign s_tready  = !hold_valid_reg || cmd_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (s_tvalid && s_tready) begin
            hold_valid_next = 1'b1;
            hold_next       = in_cmd;
        end else if (cmd_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

FILE: sv/fltab_queue.sv
// short command queue between the front and back stages
`default_nettype none

module fltab_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire fltab_pkg::cmd_t in_cmd,
    output logic                 out_valid,
    input  wire logic            out_pop,
    output fltab_pkg::cmd_t      out_cmd
);
    import fltab_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push, pop;

    assign in_ready  = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fltab_back.sv
// back stage: slot store, free stack, visit scan and result register
`default_nettype none

module fltab_back #(
    parameter int CAPACITY = 64
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire fltab_pkg::cmd_t q_cmd,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output fltab_pkg::res_t      res
);
    import fltab_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ACT      = 3'd1;
    localparam logic [2:0] S_SCAN_RD  = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;

    logic [2:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] in_use_reg, in_use_next;
    logic [CAPACITY-1:0] written_reg, written_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [VALUE_W-1:0]  pend_value_reg, pend_value_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_reg, out_next;

    logic [VALUE_W-1:0]  store_mem [CAPACITY];
    logic [IDX_W-1:0]    stack_mem [CAPACITY];
    logic [VALUE_W-1:0]  store_rd_reg;
    logic [IDX_W-1:0]    stack_rd_reg;

    logic                store_re, store_we, stack_re, stack_we;
    logic [IDX_W-1:0]    store_ra, store_wa, stack_ra, stack_wa;
    logic [VALUE_W-1:0]  store_wd;
    logic [IDX_W-1:0]    stack_wd;

    logic                out_free;
    logic [IDX_W-1:0]    top_idx, id_idx, scan_idx, add_slot;
    logic                scan_hit;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign out_free  = !out_valid_reg || res_ready;

    assign top_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign id_idx   = cmd_reg.slot_id[IDX_W-1:0];
    assign scan_idx = scan_reg[IDX_W-1:0];
    // entries of the free stack never written are taken as their own index
    assign add_slot = written_reg[top_idx] ? stack_rd_reg : top_idx;
    assign scan_hit = in_use_reg[scan_idx] && (store_rd_reg != '0);

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        in_use_next     = in_use_reg;
        written_next    = written_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_value_next = pend_value_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        store_re        = 1'b0;
        store_ra        = q_cmd.slot_id[IDX_W-1:0];
        store_we        = 1'b0;
        store_wa        = add_slot;
        store_wd        = cmd_reg.object_value;
        stack_re        = 1'b0;
        stack_ra        = top_idx;
        stack_we        = 1'b0;
        stack_wa        = count_reg[IDX_W-1:0];
        stack_wd        = id_idx;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    store_re   = 1'b1;
                    stack_re   = 1'b1;
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                unique case (cmd_reg.action)
                    ACT_ADD: begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                            if (count_reg == '0) begin
                                out_next = '{slot: '0, value: '0, status: ST_FULL, last: 1'b1};
                            end else begin
                                store_we              = 1'b1;
                                in_use_next[add_slot] = 1'b1;
                                count_next            = count_reg - CNT_W'(1);
                                out_next = '{slot: SLOT_W'(add_slot), value: '0,
                                             status: ST_OK, last: 1'b1};
                            end
                        end
                    end
                    ACT_REMOVE: begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                            if (cmd_reg.range_err) begin
                                out_next = '{slot: cmd_reg.slot_id[SLOT_W-1:0], value: '0,
                                             status: ST_RANGE, last: 1'b1};
                            end else if (!in_use_reg[id_idx] ||
                                         count_reg >= CNT_W'(CAPACITY)) begin
                                out_next = '{slot: SLOT_W'(id_idx), value: '0,
                                             status: ST_FREE, last: 1'b1};
                            end else begin
                                // cleared in_use makes the stored value read as zero
                                stack_we                        = 1'b1;
                                written_next[count_reg[IDX_W-1:0]] = 1'b1;
                                count_next                      = count_reg + CNT_W'(1);
                                in_use_next[id_idx]             = 1'b0;
                                out_next = '{slot: SLOT_W'(id_idx), value: '0,
                                             status: ST_OK, last: 1'b1};
                            end
                        end
                    end
                    ACT_GET: begin
                        if (out_free) begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                            if (cmd_reg.range_err) begin
                                out_next = '{slot: cmd_reg.slot_id[SLOT_W-1:0], value: '0,
                                             status: ST_RANGE, last: 1'b1};
                            end else begin
                                out_next = '{slot: SLOT_W'(id_idx),
                                             value: in_use_reg[id_idx] ? store_rd_reg : '0,
                                             status: ST_OK, last: 1'b1};
                            end
                        end
                    end
                    ACT_VISIT: begin
                        scan_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN_RD;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (scan_reg == CNT_W'(CAPACITY)) begin
                    if (!pend_valid_reg) begin
                        state_next = S_IDLE;
                    end else if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_next = '{slot: SLOT_W'(pend_slot_reg), value: pend_value_reg,
                                     status: ST_OK, last: 1'b1};
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end else begin
                    store_re   = 1'b1;
                    store_ra   = scan_idx;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!scan_hit) begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end else if (!pend_valid_reg || out_free) begin
                    // the held hit is known not to be last once another hit shows up
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_next = '{slot: SLOT_W'(pend_slot_reg), value: pend_value_reg,
                                     status: ST_OK, last: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = scan_idx;
                    pend_value_next = store_rd_reg;
                    scan_next       = scan_reg + CNT_W'(1);
                    state_next      = S_SCAN_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (store_re) begin
            store_rd_reg <= store_mem[store_ra];
        end
        if (store_we) begin
            store_mem[store_wa] <= store_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_re) begin
            stack_rd_reg <= stack_mem[stack_ra];
        end
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= CNT_W'(CAPACITY);
            in_use_reg     <= '0;
            written_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            in_use_reg     <= in_use_next;
            written_reg    <= written_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        cmd_reg        <= cmd_next;
        scan_reg       <= scan_next;
        pend_slot_reg  <= pend_slot_next;
        pend_value_reg <= pend_value_next;
        out_reg        <= out_next;
    end

endmodule

`default_nettype wire

FILE: sv/free_list_handle_table.sv
// top level of the free-list handle table
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tdata: slot_id, object_value; s_tuser: action
// m_       out  m_tvalid/m_tready    m_tdata: slot_out, value_out; m_tuser: status;
//                                    m_tlast: is_last
//
// add, remove and get in the back stage: S_IDLE pops the queue and issues the slot
// store / free stack reads, S_ACT then acts on the registered data once the result register is free
// a visit reads the store and checks each slot in turn, then closes with the held hit, if any
// reset is synchronous; a slot not in use reads zero and the stack reads its own index
// until written, tracked by per-slot flops, so no clearing pass is needed
// a stalled m_ side holds the result register; front and queue fill up behind it
`default_nettype none

module free_list_handle_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [6:0] slot_id, [38:7] object_value, [39] zero
    input  wire logic [fltab_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  wire logic [fltab_pkg::ACTION_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [5:0] slot_out, [37:6] value_out, [39:38] zero
    output logic [fltab_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] status
    output logic [fltab_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                 m_tlast
);
    import fltab_pkg::*;

    // front to queue
    logic fr_valid, fr_ready;
    cmd_t fr_cmd;

    // queue to back
    logic q_valid, q_pop;
    cmd_t q_cmd;

    res_t res;

    fltab_front #(
        .CAPACITY(CAPACITY)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fr_valid),
        .cmd_ready (fr_ready),
        .cmd       (fr_cmd)
    );

    fltab_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_cmd    (fr_cmd),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_cmd)
    );

    fltab_back #(
        .CAPACITY(CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack result fields, zero fill to whole bytes
    assign m_tdata = {(M_TDATA_W - SLOT_W - VALUE_W)'(0), res.value, res.slot};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

endmodule

`default_nettype wire
